### rtl/psd_pkg.sv
// Shared types for the point-to-segment squared distance core.
// No dependencies; used by psd_select, psd_div, the top level and the testbench.
`timescale 1ns / 1ps

package psd_pkg;

  // Nearest feature of the segment to the query point.
  typedef enum logic [1:0] {
    REG_BEFORE   = 2'd0,
    REG_BEYOND   = 2'd1,
    REG_INTERIOR = 2'd2,
    REG_ZERO     = 2'd3
  } region_t;

  // Register stages ahead of the divider (front plus select).
  localparam int unsigned PRE_STAGES = 7;

endpackage

### rtl/psd_front.sv
// Front stages: coordinate differences, all products, dot/cross/length sums.
// No package dependency; fed by the top level.
`timescale 1ns / 1ps

module psd_front #(
  parameter int CB = 24
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_vld,
  input  logic signed [CB-1:0]       p_i [3],
  input  logic signed [CB-1:0]       a_i [3],
  input  logic signed [CB-1:0]       b_i [3],
  output logic                       vld_o,
  output logic        [2*CB+1:0]     dd_o,
  output logic signed [2*CB+3:0]     dot1_o,
  output logic signed [2*CB+3:0]     dot2_o,
  output logic signed [2*CB+2:0]     cr_o [3],
  output logic        [2*CB+1:0]     wsq_o,
  output logic        [2*CB+1:0]     vsq_o
);

  localparam int DW = CB + 1;
  localparam int PW = 2 * DW;
  localparam int SW = PW + 2;
  localparam int XW = PW + 1;
  localparam int QW = PW;

  // stage 1: differences
  logic signed [DW-1:0] d_r [3], w_r [3], v_r [3];
  logic                 v1_r;
  // stage 2: products
  logic signed [PW-1:0] sd_r [3], sw_r [3], sv_r [3], t1_r [3], t2_r [3];
  logic signed [PW-1:0] xa_r [3], xb_r [3];
  logic                 v2_r;
  // stage 3: sums
  logic        [QW-1:0] dd_r, wsq_r, vsq_r;
  logic signed [SW-1:0] dot1_r, dot2_r;
  logic signed [XW-1:0] cr_r [3];
  logic                 v3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        d_r[i] <= DW'(b_i[i]) - DW'(a_i[i]);
        w_r[i] <= DW'(p_i[i]) - DW'(a_i[i]);
        v_r[i] <= DW'(p_i[i]) - DW'(b_i[i]);
        sd_r[i] <= d_r[i] * d_r[i];
        sw_r[i] <= w_r[i] * w_r[i];
        sv_r[i] <= v_r[i] * v_r[i];
        t1_r[i] <= d_r[i] * w_r[i];
        t2_r[i] <= d_r[i] * v_r[i];
        cr_r[i] <= XW'(xa_r[i]) - XW'(xb_r[i]);
      end
      // cross terms of W x D (the same magnitude as D x W)
      xa_r[0] <= d_r[2] * w_r[1];
      xb_r[0] <= d_r[1] * w_r[2];
      xa_r[1] <= d_r[0] * w_r[2];
      xb_r[1] <= d_r[2] * w_r[0];
      xa_r[2] <= d_r[1] * w_r[0];
      xb_r[2] <= d_r[0] * w_r[1];
      dd_r   <= $unsigned(sd_r[0]) + $unsigned(sd_r[1]) + $unsigned(sd_r[2]);
      wsq_r  <= $unsigned(sw_r[0]) + $unsigned(sw_r[1]) + $unsigned(sw_r[2]);
      vsq_r  <= $unsigned(sv_r[0]) + $unsigned(sv_r[1]) + $unsigned(sv_r[2]);
      dot1_r <= SW'(t1_r[0]) + SW'(t1_r[1]) + SW'(t1_r[2]);
      dot2_r <= SW'(t2_r[0]) + SW'(t2_r[1]) + SW'(t2_r[2]);
    end
  end

  assign vld_o  = v3_r;
  assign dd_o   = dd_r;
  assign dot1_o = dot1_r;
  assign dot2_o = dot2_r;
  assign cr_o   = cr_r;
  assign wsq_o  = wsq_r;
  assign vsq_o  = vsq_r;

endmodule

### rtl/psd_select.sv
// Region decision and squared cross magnitude, split into half-width products.
// Depends on psd_pkg for region_t; feeds psd_div.
`timescale 1ns / 1ps

module psd_select #(
  parameter int CB = 24
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   vld_i,
  input  logic        [2*CB+1:0] dd_i,
  input  logic signed [2*CB+3:0] dot1_i,
  input  logic signed [2*CB+3:0] dot2_i,
  input  logic signed [2*CB+2:0] cr_i [3],
  input  logic        [2*CB+1:0] wsq_i,
  input  logic        [2*CB+1:0] vsq_i,
  output logic                   vld_o,
  output logic        [4*CB+5:0] num_o,
  output logic        [2*CB+1:0] den_o,
  output psd_pkg::region_t       rgn_o
);

  localparam int QW = 2 * CB + 2;
  localparam int SW = QW + 2;
  localparam int MW = QW;
  localparam int ML = (MW + 1) / 2;
  localparam int MH = MW - ML;
  localparam int NW = 2 * MW + 2;

  psd_pkg::region_t rgn4_r, rgn5_r, rgn6_r, rgn_r, rgn4_nxt;
  logic [QW-1:0]    dd4_r, dd5_r, dd6_r, end4_r, end5_r, end6_r;
  logic [MW-1:0]    mag_r [3];
  logic [2*MH-1:0]  hh_r [3];
  logic [MH+ML-1:0] hl_r [3];
  logic [2*ML-1:0]  ll_r [3];
  logic [NW-1:0]    sq_r [3];
  logic [NW-1:0]    num_r;
  logic [QW-1:0]    den_r;
  logic             v4_r, v5_r, v6_r, v7_r;
  logic [MH-1:0]    mh [3];
  logic [ML-1:0]    ml [3];

  // dot2 here is D.(P-B); a positive value means the point lies beyond B
  always_comb begin
    if (dd_i == '0) begin
      rgn4_nxt = psd_pkg::REG_ZERO;
    end else if (dot1_i[SW-1]) begin
      rgn4_nxt = psd_pkg::REG_BEFORE;
    end else if (!dot2_i[SW-1] && (dot2_i != '0)) begin
      rgn4_nxt = psd_pkg::REG_BEYOND;
    end else begin
      rgn4_nxt = psd_pkg::REG_INTERIOR;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ml[i] = mag_r[i][ML-1:0];
      mh[i] = mag_r[i][MW-1:ML];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else if (en) begin
      v4_r <= vld_i;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rgn4_r <= rgn4_nxt;
      dd4_r  <= dd_i;
      end4_r <= (rgn4_nxt == psd_pkg::REG_BEYOND) ? vsq_i : wsq_i;
      for (int i = 0; i < 3; i++) begin
        mag_r[i] <= MW'(cr_i[i][2*CB+2] ? -cr_i[i] : cr_i[i]);
        hh_r[i]  <= mh[i] * mh[i];
        hl_r[i]  <= mh[i] * ml[i];
        ll_r[i]  <= ml[i] * ml[i];
        sq_r[i]  <= (NW'(hh_r[i]) << (2 * ML)) + (NW'(hl_r[i]) << (ML + 1)) + NW'(ll_r[i]);
      end
      rgn5_r <= rgn4_r;
      dd5_r  <= dd4_r;
      end5_r <= end4_r;
      rgn6_r <= rgn5_r;
      dd6_r  <= dd5_r;
      end6_r <= end5_r;
      rgn_r  <= rgn6_r;
      // endpoint cases divide by one so the divider passes the value through
      if (rgn6_r == psd_pkg::REG_INTERIOR) begin
        num_r <= sq_r[0] + sq_r[1] + sq_r[2];
        den_r <= dd6_r;
      end else begin
        num_r <= NW'(end6_r);
        den_r <= QW'(1);
      end
    end
  end

  assign vld_o = v7_r;
  assign num_o = num_r;
  assign den_o = den_r;
  assign rgn_o = rgn_r;

endmodule

### rtl/psd_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Depends on psd_pkg for region_t; fed by psd_select.
`timescale 1ns / 1ps

module psd_div #(
  parameter int CB = 24
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   vld_i,
  input  logic        [4*CB+5:0] num_i,
  input  logic        [2*CB+1:0] den_i,
  input  psd_pkg::region_t       rgn_i,
  output logic                   vld_o,
  output logic        [2*CB+1:0] quo_o,
  output psd_pkg::region_t       rgn_o
);

  localparam int QW = 2 * CB + 2;
  localparam int NW = 2 * QW + 2;

  // ql holds the unconsumed low numerator bits with quotient bits shifted in below
  logic [QW-1:0]    rem_r [QW];
  logic [QW-1:0]    ql_r  [QW];
  logic [QW-1:0]    den_r [QW];
  psd_pkg::region_t rgn_r [QW];
  logic             vld_r [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [QW-1:0]    rem_in, ql_in, den_in;
    psd_pkg::region_t rgn_in;
    logic             vld_in;
    logic [QW:0]      trial;

    if (k == 0) begin : g_first
      // quotient fits QW bits, so the high part is already below den
      assign rem_in = num_i[2*QW-1:QW];
      assign ql_in  = num_i[QW-1:0];
      assign den_in = den_i;
      assign rgn_in = rgn_i;
      assign vld_in = vld_i;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign ql_in  = ql_r[k-1];
      assign den_in = den_r[k-1];
      assign rgn_in = rgn_r[k-1];
      assign vld_in = vld_r[k-1];
    end

    assign trial = {rem_in, ql_in[QW-1]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (trial >= {1'b0, den_in}) begin
          rem_r[k] <= QW'(trial - {1'b0, den_in});
          ql_r[k]  <= {ql_in[QW-2:0], 1'b1};
        end else begin
          rem_r[k] <= trial[QW-1:0];
          ql_r[k]  <= {ql_in[QW-2:0], 1'b0};
        end
        den_r[k] <= den_in;
        rgn_r[k] <= rgn_in;
      end
    end
  end

  assign vld_o = vld_r[QW-1];
  assign quo_o = ql_r[QW-1];
  assign rgn_o = rgn_r[QW-1];

`ifndef ASSERT_OFF
  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[QW-1] |-> rem_r[QW-1] < den_r[QW-1])
    else $error("divider remainder not below divisor");

  a_endpoint_unit_den: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[QW-1] && (rgn_r[QW-1] != psd_pkg::REG_INTERIOR) |-> den_r[QW-1] == QW'(1))
    else $error("endpoint result not divided by one");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[QW-1] && !en |=> vld_r[QW-1] && $stable(ql_r[QW-1]) && $stable(rgn_r[QW-1]))
    else $error("last divider stage changed while stalled");
`endif

endmodule

### rtl/point_segment_distance_sqr_core.sv
// Top level of the point-to-segment squared distance core.
// Depends on psd_pkg, psd_front, psd_select and psd_div.
`timescale 1ns / 1ps

// Squared distance from a 3D point P to the segment A-B, all coordinates signed
// fixed point. One transfer is accepted every cycle while no finished result
// is held at the output; each result passes seven arithmetic stages and then
// the one-bit-per-stage divider. The whole pipeline advances together and
// holds while a finished result waits on out_ready. region tells which
// formula produced dist_sqr: 0 nearest to A, 1 nearest to B, 2 perpendicular
// foot inside the segment (quotient truncated), 3 degenerate segment with A
// equal to B (distance to A). dist_sqr carries twice the input fraction bits.

module point_segment_distance_sqr_core #(
  parameter int COORD_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] in_point_x,
  input  logic signed [COORD_BITS-1:0] in_point_y,
  input  logic signed [COORD_BITS-1:0] in_point_z,
  input  logic signed [COORD_BITS-1:0] in_start_x,
  input  logic signed [COORD_BITS-1:0] in_start_y,
  input  logic signed [COORD_BITS-1:0] in_start_z,
  input  logic signed [COORD_BITS-1:0] in_end_x,
  input  logic signed [COORD_BITS-1:0] in_end_y,
  input  logic signed [COORD_BITS-1:0] in_end_z,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [2*COORD_BITS+1:0]      out_dist_sqr,
  output logic [1:0]                   out_region
);

  localparam int CB = COORD_BITS;

  logic                   en;
  logic signed [CB-1:0]   p_in [3], a_in [3], b_in [3];

  logic                   f_vld;
  logic        [2*CB+1:0] f_dd, f_wsq, f_vsq;
  logic signed [2*CB+3:0] f_dot1, f_dot2;
  logic signed [2*CB+2:0] f_cr [3];

  logic                   s_vld;
  logic        [4*CB+5:0] s_num;
  logic        [2*CB+1:0] s_den;
  psd_pkg::region_t       s_rgn, d_rgn;

  // advance every stage unless a finished result is held at the output
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  assign p_in[0] = in_point_x;
  assign p_in[1] = in_point_y;
  assign p_in[2] = in_point_z;
  assign a_in[0] = in_start_x;
  assign a_in[1] = in_start_y;
  assign a_in[2] = in_start_z;
  assign b_in[0] = in_end_x;
  assign b_in[1] = in_end_y;
  assign b_in[2] = in_end_z;

  // differences, products and sums: dot products, cross product, lengths
  psd_front #(.CB(CB)) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_vld (in_valid),
    .p_i    (p_in),
    .a_i    (a_in),
    .b_i    (b_in),
    .vld_o  (f_vld),
    .dd_o   (f_dd),
    .dot1_o (f_dot1),
    .dot2_o (f_dot2),
    .cr_o   (f_cr),
    .wsq_o  (f_wsq),
    .vsq_o  (f_vsq)
  );

  // region choice and |D x W|^2; endpoint cases pass through with divisor one
  psd_select #(.CB(CB)) u_select (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (f_vld),
    .dd_i   (f_dd),
    .dot1_i (f_dot1),
    .dot2_i (f_dot2),
    .cr_i   (f_cr),
    .wsq_i  (f_wsq),
    .vsq_i  (f_vsq),
    .vld_o  (s_vld),
    .num_o  (s_num),
    .den_o  (s_den),
    .rgn_o  (s_rgn)
  );

  // the last divider stage doubles as the output register
  psd_div #(.CB(CB)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .vld_i (s_vld),
    .num_i (s_num),
    .den_i (s_den),
    .rgn_i (s_rgn),
    .vld_o (out_valid),
    .quo_o (out_dist_sqr),
    .rgn_o (d_rgn)
  );

  assign out_region = d_rgn;

endmodule

### test/psd_checker.sv
// Scoreboard for point_segment_distance_sqr_core: predicts each transfer's result.
// Depends on psd_pkg; instantiated by tb_point_segment_distance_sqr_core.
`timescale 1ns / 1ps

module psd_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic signed [23:0]  in_point_x,
  input  logic signed [23:0]  in_point_y,
  input  logic signed [23:0]  in_point_z,
  input  logic signed [23:0]  in_start_x,
  input  logic signed [23:0]  in_start_y,
  input  logic signed [23:0]  in_start_z,
  input  logic signed [23:0]  in_end_x,
  input  logic signed [23:0]  in_end_y,
  input  logic signed [23:0]  in_end_z,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic [49:0]         out_dist_sqr,
  input  logic [1:0]          out_region,
  output int                  err_count,
  output int                  pending
);

  typedef struct packed {
    logic [49:0]      dist_sqr;
    psd_pkg::region_t region;
  } dist_result_t;

  dist_result_t expected_q[$];

  function automatic logic [127:0] square(longint v);
    logic [127:0] m;
    m = {64'd0, (v < 0) ? -v : v};
    return m * m;
  endfunction

  function automatic dist_result_t nearest_dist(
    longint px, longint py, longint pz,
    longint ax, longint ay, longint az,
    longint bx, longint by, longint bz);
    longint dx, dy, dz, wx, wy, wz, vx, vy, vz;
    logic [127:0] seg_len, num;
    dist_result_t r;
    dx = bx - ax; dy = by - ay; dz = bz - az;
    wx = px - ax; wy = py - ay; wz = pz - az;
    vx = px - bx; vy = py - by; vz = pz - bz;
    seg_len = square(dx) + square(dy) + square(dz);
    if (seg_len == 0) begin
      num = square(wx) + square(wy) + square(wz);
      r.region = psd_pkg::REG_ZERO;
    end else if (dx * wx + dy * wy + dz * wz < 0) begin
      num = square(wx) + square(wy) + square(wz);
      r.region = psd_pkg::REG_BEFORE;
    end else if (dx * vx + dy * vy + dz * vz > 0) begin
      num = square(vx) + square(vy) + square(vz);
      r.region = psd_pkg::REG_BEYOND;
    end else begin
      num = square(dz * wy - dy * wz) + square(dx * wz - dz * wx)
          + square(dy * wx - dx * wy);
      num = num / seg_len;
      r.region = psd_pkg::REG_INTERIOR;
    end
    r.dist_sqr = num[49:0];
    return r;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  always @(posedge clk) begin
    dist_result_t e;
    if (!rst_n) begin
      err_count = 0;
      pending = 0;
    end else begin
      if (in_valid && in_ready)
        expected_q.push_back(nearest_dist(in_point_x, in_point_y, in_point_z,
          in_start_x, in_start_y, in_start_z, in_end_x, in_end_y, in_end_z));
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          report("unexpected result", 64'(out_dist_sqr), 64'd0);
        end else begin
          e = expected_q.pop_front();
          if (out_dist_sqr !== e.dist_sqr)
            report("dist_sqr", 64'(out_dist_sqr), 64'(e.dist_sqr));
          if (out_region !== e.region)
            report("region", 64'(out_region), 64'(e.region));
        end
      end
      pending = expected_q.size();
    end
  end

endmodule

### test/tb_point_segment_distance_sqr_core.sv
// Testbench top for point_segment_distance_sqr_core: stimulus and verdict.
// Depends on psd_pkg, the core under rtl and psd_checker.
`timescale 1ns / 1ps

module tb_point_segment_distance_sqr_core;

  localparam int CYCLE_LIMIT = 300000;
  localparam int MAXC = 8388607;
  localparam int MINC = -8388608;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [23:0] in_point_x = '0, in_point_y = '0, in_point_z = '0;
  logic signed [23:0] in_start_x = '0, in_start_y = '0, in_start_z = '0;
  logic signed [23:0] in_end_x = '0, in_end_y = '0, in_end_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [49:0] out_dist_sqr;
  logic [1:0] out_region;
  int err_count, pending;

  // Idling knobs shared with the receiver process, and the watchdog's cycle counter.
  bit idle_on = 1'b1;
  bit hold_req = 1'b0;
  int cycles = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  point_segment_distance_sqr_core #(.COORD_BITS(24)) u_dut (.*);

  psd_checker u_chk (.*);

  // Watchdog: end the run if the pipeline never drains.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Receiver: random stall bursts, one long hold-off on request, none at the end.
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        n = 400;
        while (n > 0) begin
          @(posedge clk);
          n--;
        end
        hold_req = 1'b0;
        out_ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Offer one point/segment and hold it until the transfer; optionally idle after.
  task automatic send_query(int px, int py, int pz, int ax, int ay, int az,
                            int bx, int by, int bz);
    in_valid   <= 1'b1;
    in_point_x <= 24'(px); in_point_y <= 24'(py); in_point_z <= 24'(pz);
    in_start_x <= 24'(ax); in_start_y <= 24'(ay); in_start_z <= 24'(az);
    in_end_x   <= 24'(bx); in_end_y   <= 24'(by); in_end_z   <= 24'(bz);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  function automatic int rnd_coord(int span);
    if (span == 0) return int'($urandom_range(0, 32'hFFFFFF)) - 8388608;
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  initial begin
    int ax, ay, az, bx, by, bz, px, py, pz, span, t, k;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, zero-length segments, each region, zero dot products.
    send_query(0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_query(MAXC, MAXC, MAXC, MINC, MINC, MINC, MINC, MINC, MINC);
    send_query(MINC, MINC, MINC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC);
    send_query(MAXC, MAXC, MAXC, MINC, MINC, MINC, MAXC, MAXC, MAXC);
    send_query(MAXC, MINC, MAXC, MINC, MAXC, MINC, MAXC, MAXC, MINC);
    send_query(MINC, MAXC, MINC, MAXC, MINC, MAXC, MINC, MINC, MAXC);
    send_query(-256, 0, 0, 0, 0, 0, 256, 0, 0);
    send_query(512, 0, 0, 0, 0, 0, 256, 0, 0);
    send_query(128, 300, -7, 0, 0, 0, 256, 0, 0);
    send_query(0, 100, 0, 0, 0, 0, 256, 0, 0);
    send_query(256, 100, 0, 0, 0, 0, 256, 0, 0);
    send_query(5, 7, 9, 1, 2, 3, 1, 2, 3);
    send_query(MAXC, MAXC, MAXC, MINC, MINC, MINC, MINC + 1, MINC, MINC);
    send_query(MINC, MAXC, 0, MAXC, MINC, 0, MINC, MAXC, 1);
    send_query(1, 1, 1, MINC, MAXC, MINC, MAXC, MINC, MAXC);
    send_query(-1, -1, -1, 0, 0, 0, 3, 5, 7);
    send_query(3, 1, 0, 0, 0, 0, 7, 3, 0);

    for (k = 0; k < 420; k++) begin
      if (k == 120) hold_req = 1'b1;
      if (k == 340) idle_on = 1'b0;
      t = $urandom_range(0, 9);
      span = (t < 3) ? 0 : (t < 6) ? 2000 : 50;
      ax = rnd_coord(span); ay = rnd_coord(span); az = rnd_coord(span);
      bx = rnd_coord(span); by = rnd_coord(span); bz = rnd_coord(span);
      if (t == 9) begin
        bx = ax; by = ay; bz = az;
      end
      px = rnd_coord(span); py = rnd_coord(span); pz = rnd_coord(span);
      send_query(px, py, pz, ax, ay, az, bx, by, bz);
    end
    in_valid <= 1'b0;

    wait (pending == 0);
    repeat (100) @(posedge clk);
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
